// ----- design/msm_pkg.sv -----
// Shared constants, types and helper functions for the message slot manager.
package msm_pkg;

	// Memory layout of one slot: status byte, reserved header bytes, then the body.
	localparam int SLOT_COUNT      = 4;
	localparam int SLOT_BYTES      = 120;
	localparam int HEADER_RESERVED = 7;
	localparam int BODY_BYTES      = 112;

	// Field widths.
	localparam int ADDR_W = 9;
	localparam int BYTE_W = 8;
	localparam int IDX_W  = 8;
	localparam int OP_W   = 3;
	localparam int MOP_W  = 2;
	localparam int SLOT_W = $clog2(SLOT_COUNT + 1);
	localparam int CNT_W  = 3;
	localparam int LIDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int POS_W  = $clog2(BODY_BYTES + 1);

	// Operation codes.
	localparam logic [OP_W-1:0] OP_NEW    = 3'd0;
	localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
	localparam logic [OP_W-1:0] OP_OPEN   = 3'd2;
	localparam logic [OP_W-1:0] OP_READ   = 3'd3;
	localparam logic [OP_W-1:0] OP_CLOSE  = 3'd4;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd5;
	localparam logic [OP_W-1:0] OP_QUERY  = 3'd6;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd7;

	// Memory request codes.
	localparam logic [MOP_W-1:0] MEM_NONE  = 2'd0;
	localparam logic [MOP_W-1:0] MEM_READ  = 2'd1;
	localparam logic [MOP_W-1:0] MEM_WRITE = 2'd2;

	// Status byte written when a message is created.
	localparam logic [BYTE_W-1:0] STATUS_NEW = 8'd1;

	// Slot list commands.
	localparam logic [1:0] LST_NOP    = 2'd0;
	localparam logic [1:0] LST_APPEND = 2'd1;
	localparam logic [1:0] LST_SHIFT  = 2'd2;
	localparam logic [1:0] LST_CLEAR  = 2'd3;

	// Address unit operand selection.
	localparam logic AGU_BODY = 1'b0;
	localparam logic AGU_HDR  = 1'b1;

	typedef struct packed {
		logic [1:0]        kind;
		logic [CNT_W-1:0]  rd_ptr;
		logic [CNT_W-1:0]  wr_ptr;
		logic [SLOT_W-1:0] slot;
	} lst_cmd_t;

	typedef struct packed {
		logic en;
		logic sel;
	} agu_req_t;

	// First byte address of a one-based slot number; slot zero maps to slot one.
	function automatic logic [ADDR_W-1:0] slot_start(input logic [SLOT_W-1:0] slot);
		int s;
		s = (slot == '0) ? 0 : int'(slot) - 1;
		return ADDR_W'(s * SLOT_BYTES);
	endfunction

endpackage

// ----- design/message_slot_manager_top.sv -----
// Top level of the message slot manager: operation sequencer and result register.
//
// The block keeps an age-ordered list of message slots and produces at most one memory
// request per operation for an external byte memory.
// Input channel s_*: one item is one operation (opcode in s_tuser, index and
// character in s_tdata). Output channel m_*: exactly one result item per
// operation, carrying the memory request, the ok and end-of-text flags and
// the list status after the operation.
// Items are handled one at a time. A small sequencer steps the slot list one
// entry per cycle and uses one shared address adder. Delete moves the later
// entries down one at a time, and new, on a list that is not full, scans every
// stored entry for the free slot. s_tready is high only while no item is in
// work and no result is waiting, so a new item is taken only once the result
// has been accepted.
// When the receiver stalls, the result holds on m_tdata and no new item is
// taken until it has been accepted.
// After reset the list is empty, no body is open and the block is ready at
// once; there is no clearing pass.
module message_slot_manager_top
	import msm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // msg_index[7:0], data_byte[15:8]
	input  logic [2:0]  s_tuser,   // opcode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // mem_op[1:0], byte_addr[10:2], mem_wdata[18:11],
	                               // ok[19], end_of_text[20], stored_count[23:21],
	                               // is_empty[24], is_full[25], zero[31:26]
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WALK = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_RESP = 3'd4;

	logic [2:0]            state_q;
	logic [OP_W-1:0]       op_q;
	logic [IDX_W-1:0]      idx_q;
	logic [BYTE_W-1:0]     data_q;
	logic [CNT_W-1:0]      ptr_q;
	logic [SLOT_COUNT-1:0] used_q;
	logic [ADDR_W-1:0]     start_q;
	logic [ADDR_W-1:0]     base_q;
	logic [POS_W-1:0]      pos_q;
	logic                  open_q;
	logic [MOP_W-1:0]      mop_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [BYTE_W-1:0]     wdata_q;
	logic                  ok_q;
	logic                  eot_q;

	lst_cmd_t              lcmd;
	agu_req_t              areq;
	logic [SLOT_W-1:0]     rd_slot;
	logic [CNT_W-1:0]      count;
	logic [ADDR_W-1:0]     agu_sum;
	logic [SLOT_W-1:0]     free_slot;
	logic                  idx_ok;
	logic                  body_avail;
	logic                  is_full;
	logic                  is_empty;

	msm_list u_list (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (lcmd),
		.rd_slot (rd_slot),
		.count   (count)
	);

	msm_agu u_agu (
		.clk   (clk),
		.req   (areq),
		.base  (base_q),
		.pos   (pos_q),
		.start (start_q),
		.sum_q (agu_sum)
	);

	// Condition flags for the operation in work.
	assign idx_ok     = idx_q < {{(IDX_W-CNT_W){1'b0}}, count};
	assign body_avail = open_q && (pos_q < POS_W'(BODY_BYTES));
	assign is_full    = count == CNT_W'(SLOT_COUNT);
	assign is_empty   = count == '0;

	// Lowest slot number not marked used by the list scan.
	always_comb begin
		free_slot = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_slot = SLOT_W'(i + 1);
			end
		end
	end

	// Slot list command for the current step.
	always_comb begin
		lcmd.kind   = LST_NOP;
		lcmd.rd_ptr = ptr_q;
		lcmd.wr_ptr = ptr_q;
		lcmd.slot   = free_slot;
		if (state_q == ST_WALK) begin
			unique case (op_q)
				OP_NEW: begin
					if (!is_full && ptr_q >= count) begin
						lcmd.kind = LST_APPEND;
					end
				end
				OP_DELETE: begin
					lcmd.rd_ptr = ptr_q + 1'b1;
					if (idx_ok) begin
						lcmd.kind = LST_SHIFT;
					end
				end
				OP_OPEN, OP_QUERY: begin
					lcmd.rd_ptr = idx_q[CNT_W-1:0];
				end
				OP_CLEAR: begin
					lcmd.kind = LST_CLEAR;
				end
				OP_WRITE, OP_READ, OP_CLOSE: begin
				end
			endcase
		end
	end

	// Address unit request: header offset for new and open, stream address otherwise.
	always_comb begin
		areq.en  = state_q == ST_ADD;
		areq.sel = (op_q == OP_NEW || op_q == OP_OPEN) ? AGU_HDR : AGU_BODY;
	end

	// Operation sequencer, stream state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_NEW;
			idx_q   <= '0;
			data_q  <= '0;
			ptr_q   <= '0;
			used_q  <= '0;
			start_q <= '0;
			base_q  <= '0;
			pos_q   <= '0;
			open_q  <= 1'b0;
			mop_q   <= MEM_NONE;
			addr_q  <= '0;
			wdata_q <= '0;
			ok_q    <= 1'b0;
			eot_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tuser;
						idx_q   <= s_tdata[7:0];
						data_q  <= s_tdata[15:8];
						ptr_q   <= (s_tuser == OP_DELETE) ? s_tdata[CNT_W-1:0] : '0;
						used_q  <= '0;
						mop_q   <= MEM_NONE;
						addr_q  <= '0;
						wdata_q <= '0;
						ok_q    <= 1'b0;
						eot_q   <= 1'b0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					unique case (op_q)
						OP_NEW: begin
							if (is_full) begin
								state_q <= ST_RESP;
							end else if (ptr_q < count) begin
								used_q <= used_q |
									(SLOT_COUNT'(1) << (rd_slot - 1'b1));
								ptr_q  <= ptr_q + 1'b1;
							end else begin
								start_q <= slot_start(free_slot);
								state_q <= ST_ADD;
							end
						end
						OP_WRITE, OP_READ: begin
							if (body_avail) begin
								state_q <= ST_ADD;
							end else begin
								eot_q   <= op_q == OP_READ;
								state_q <= ST_RESP;
							end
						end
						OP_OPEN: begin
							if (idx_ok) begin
								start_q <= slot_start(rd_slot);
								state_q <= ST_ADD;
							end else begin
								state_q <= ST_RESP;
							end
						end
						OP_CLOSE: begin
							open_q  <= 1'b0;
							ok_q    <= 1'b1;
							state_q <= ST_RESP;
						end
						OP_DELETE: begin
							if (!idx_ok) begin
								state_q <= ST_RESP;
							end else if (CNT_W'(ptr_q + 1'b1) == count) begin
								ok_q    <= 1'b1;
								state_q <= ST_RESP;
							end else begin
								ptr_q <= ptr_q + 1'b1;
							end
						end
						OP_QUERY: begin
							if (idx_ok) begin
								mop_q  <= MEM_READ;
								addr_q <= slot_start(rd_slot);
								ok_q   <= 1'b1;
							end
							state_q <= ST_RESP;
						end
						OP_CLEAR: begin
							ok_q    <= 1'b1;
							state_q <= ST_RESP;
						end
					endcase
				end
				ST_ADD: begin
					// The status write of a new message goes out from the slot start.
					if (op_q == OP_NEW) begin
						mop_q   <= MEM_WRITE;
						addr_q  <= start_q;
						wdata_q <= STATUS_NEW;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (op_q == OP_NEW || op_q == OP_OPEN) begin
						base_q <= agu_sum;
						pos_q  <= '0;
						open_q <= 1'b1;
						ok_q   <= 1'b1;
					end else if (op_q == OP_WRITE) begin
						mop_q   <= MEM_WRITE;
						addr_q  <= agu_sum;
						wdata_q <= data_q;
						pos_q   <= pos_q + 1'b1;
						ok_q    <= 1'b1;
					end else if (op_q == OP_READ) begin
						mop_q  <= MEM_READ;
						addr_q <= agu_sum;
						pos_q  <= pos_q + 1'b1;
						ok_q   <= 1'b1;
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Handshake and result packing.
	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = state_q == ST_RESP;
	assign m_tdata  = {6'b0, is_full, is_empty, count, eot_q, ok_q, wdata_q, addr_q, mop_q};

	// A result that refuses a read by end of text never also reports success.
	a_eot_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(eot_q && ok_q))
		else $error("end_of_text and ok both set");

	// Every memory request belongs to an accepted operation.
	a_req_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && mop_q != MEM_NONE) |-> ok_q)
		else $error("memory request on a refused operation");

	// The list never holds more entries than there are slots.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(SLOT_COUNT))
		else $error("stored count beyond slot count");

	// The stream position never runs past the body.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(BODY_BYTES))
		else $error("body position beyond body length");

	// The list count only changes while an operation is in the walk step.
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_WALK) |=> $stable(count))
		else $error("stored count changed outside the list walk");

endmodule

// ----- design/msm_list.sv -----
// Age-ordered slot list with its fill count, one entry moved per command.
module msm_list
	import msm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  lst_cmd_t            cmd,
	output logic [SLOT_W-1:0]   rd_slot,
	output logic [CNT_W-1:0]    count
);

	logic [SLOT_W-1:0] list_q [SLOT_COUNT];
	logic [CNT_W-1:0]  count_q;

	// One read port, addressed by the sequencer.
	assign rd_slot = list_q[cmd.rd_ptr[LIDX_W-1:0]];
	assign count   = count_q;

	// Append at the tail, move one entry down, or empty the whole list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				list_q[i] <= '0;
			end
			count_q <= '0;
		end else begin
			unique case (cmd.kind)
				LST_APPEND: begin
					list_q[count_q[LIDX_W-1:0]] <= cmd.slot;
					count_q <= count_q + 1'b1;
				end
				LST_SHIFT: begin
					if (CNT_W'(cmd.wr_ptr + 1'b1) == count_q) begin
						list_q[cmd.wr_ptr[LIDX_W-1:0]] <= '0;
						count_q <= count_q - 1'b1;
					end else begin
						list_q[cmd.wr_ptr[LIDX_W-1:0]] <= rd_slot;
					end
				end
				LST_CLEAR: begin
					for (int i = 0; i < SLOT_COUNT; i++) begin
						list_q[i] <= '0;
					end
					count_q <= '0;
				end
				LST_NOP: begin
				end
			endcase
		end
	end

endmodule

// ----- design/msm_agu.sv -----
// Shared address adder: body stream address or body base from a slot start.
module msm_agu
	import msm_pkg::*;
(
	input  logic              clk,
	input  agu_req_t          req,
	input  logic [ADDR_W-1:0] base,
	input  logic [POS_W-1:0]  pos,
	input  logic [ADDR_W-1:0] start,
	output logic [ADDR_W-1:0] sum_q
);

	logic [ADDR_W-1:0] opa;
	logic [ADDR_W-1:0] opb;

	// Operand selection for the single adder.
	always_comb begin
		if (req.sel == AGU_HDR) begin
			opa = start;
			opb = ADDR_W'(HEADER_RESERVED + 1);
		end else begin
			opa = base;
			opb = ADDR_W'(pos);
		end
	end

	// Sum wraps at the top of the address space.
	always_ff @(posedge clk) begin
		if (req.en) begin
			sum_q <= opa + opb;
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the message slot manager: directed, streaming and random operations.
module tb_top;
	import msm_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 370;

	// One result item, split into its fields.
	typedef struct packed {
		logic [MOP_W-1:0]  mop;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] wdata;
		logic              ok;
		logic              eot;
		logic [CNT_W-1:0]  cnt;
		logic              empty;
		logic              full;
	} slot_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // msg_index[7:0], data_byte[15:8]
	logic [2:0]  s_tuser;   // opcode[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // mem_op[1:0], byte_addr[10:2], mem_wdata[18:11], ok[19],
	                        // end_of_text[20], stored_count[23:21], is_empty[24], is_full[25]

	// Shadow copy of the slot list and the open body.
	logic [SLOT_W-1:0] shadow_slots [SLOT_COUNT];
	int                shadow_count;
	logic [ADDR_W-1:0] shadow_base;
	int                shadow_pos;
	bit                shadow_open;

	slot_result_t pending_results[$];
	int           mismatch_count;
	int           items_sent;
	int           send_idle_pct;
	int           recv_idle_pct;
	bit           hold_request;

	message_slot_manager_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Clock with a period of 10.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Status byte address of a one-based slot number.
	function automatic logic [ADDR_W-1:0] status_addr(input int slot);
		return ADDR_W'((slot - 1) * SLOT_BYTES);
	endfunction

	// Works out the result of one operation and updates the shadow state.
	function automatic slot_result_t predict_slot_op(input logic [OP_W-1:0] op,
			input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] chr);
		slot_result_t r;
		int           s;
		int           k;
		bit           taken;
		r = '0;
		case (op)
			OP_NEW: begin
				if (shadow_count < SLOT_COUNT) begin
					// Lowest slot number not yet in the list.
					for (s = 1; s <= SLOT_COUNT; s++) begin
						taken = 1'b0;
						for (k = 0; k < shadow_count; k++)
							if (shadow_slots[k] == s)
								taken = 1'b1;
						if (!taken)
							break;
					end
					shadow_slots[shadow_count] = SLOT_W'(s);
					shadow_count++;
					r.mop       = MEM_WRITE;
					r.addr      = status_addr(s);
					r.wdata     = STATUS_NEW;
					shadow_base = r.addr + ADDR_W'(HEADER_RESERVED + 1);
					shadow_pos  = 0;
					shadow_open = 1'b1;
					r.ok        = 1'b1;
				end
			end
			OP_WRITE: begin
				if (shadow_open && shadow_pos < BODY_BYTES) begin
					r.mop   = MEM_WRITE;
					r.addr  = shadow_base + ADDR_W'(shadow_pos);
					r.wdata = chr;
					r.ok    = 1'b1;
					shadow_pos++;
				end
			end
			OP_OPEN: begin
				if (idx < shadow_count) begin
					shadow_base = status_addr(shadow_slots[idx]) + ADDR_W'(HEADER_RESERVED + 1);
					shadow_pos  = 0;
					shadow_open = 1'b1;
					r.ok        = 1'b1;
				end
			end
			OP_READ: begin
				if (!shadow_open || shadow_pos >= BODY_BYTES) begin
					r.eot = 1'b1;
				end else begin
					r.mop  = MEM_READ;
					r.addr = shadow_base + ADDR_W'(shadow_pos);
					r.ok   = 1'b1;
					shadow_pos++;
				end
			end
			OP_CLOSE: begin
				shadow_open = 1'b0;
				r.ok        = 1'b1;
			end
			OP_DELETE: begin
				// Later entries move down one place to close the gap.
				if (idx < shadow_count) begin
					for (k = idx + 1; k < shadow_count; k++)
						shadow_slots[k - 1] = shadow_slots[k];
					shadow_slots[shadow_count - 1] = '0;
					shadow_count--;
					r.ok = 1'b1;
				end
			end
			OP_QUERY: begin
				if (idx < shadow_count) begin
					r.mop  = MEM_READ;
					r.addr = status_addr(shadow_slots[idx]);
					r.ok   = 1'b1;
				end
			end
			OP_CLEAR: begin
				for (k = 0; k < SLOT_COUNT; k++)
					shadow_slots[k] = '0;
				shadow_count = 0;
				r.ok         = 1'b1;
			end
			default: begin
			end
		endcase
		r.cnt   = CNT_W'(shadow_count);
		r.empty = (shadow_count == 0);
		r.full  = (shadow_count == SLOT_COUNT);
		return r;
	endfunction

	// Offers one operation, with random idle cycles first, and records its expected result.
	task automatic send_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
			input logic [BYTE_W-1:0] chr);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {chr, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(predict_slot_op(op, idx, chr));
		items_sent++;
		@(negedge clk);
	endtask

	// Stops offering and waits until every expected result has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Result checker: each result item against the oldest expectation.
	always @(posedge clk) begin
		slot_result_t want;
		slot_result_t got;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			got = {m_tdata[1:0], m_tdata[10:2], m_tdata[18:11], m_tdata[19], m_tdata[20],
			       m_tdata[23:21], m_tdata[24], m_tdata[25]};
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("mem_op", want.mop, got.mop);
				compare_field("byte_addr", want.addr, got.addr);
				compare_field("mem_wdata", want.wdata, got.wdata);
				compare_field("ok", want.ok, got.ok);
				compare_field("end_of_text", want.eot, got.eot);
				compare_field("stored_count", want.cnt, got.cnt);
				compare_field("is_empty", want.empty, got.empty);
				compare_field("is_full", want.full, got.full);
			end
		end
	end

	// Receiver: random stalls, and one long hold-off when asked for.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Every operation on an empty list, then operations on a full list and at the list edges.
	task automatic test_directed();
		int n;
		send_op(OP_READ, 8'd0, 8'd0);
		send_op(OP_WRITE, 8'd0, 8'hFF);
		send_op(OP_OPEN, 8'd0, 8'd0);
		send_op(OP_DELETE, 8'd0, 8'd0);
		send_op(OP_QUERY, 8'd0, 8'd0);
		send_op(OP_CLOSE, 8'd0, 8'd0);
		send_op(OP_CLEAR, 8'd0, 8'd0);
		for (n = 0; n < SLOT_COUNT; n++) begin
			send_op(OP_NEW, 8'hFF, 8'hFF);
			send_op(OP_WRITE, 8'hFF, (n % 2 == 0) ? 8'h00 : 8'hFF);
		end
		// New on a full list is refused.
		send_op(OP_NEW, 8'd0, 8'd0);
		send_op(OP_QUERY, 8'(SLOT_COUNT - 1), 8'd0);
		send_op(OP_QUERY, 8'(SLOT_COUNT), 8'd0);
		send_op(OP_QUERY, 8'hFF, 8'd0);
		send_op(OP_OPEN, 8'd2, 8'd0);
		send_op(OP_READ, 8'd0, 8'd0);
		// Deleting from the middle leaves a hole that the next new fills.
		send_op(OP_DELETE, 8'd1, 8'd0);
		send_op(OP_DELETE, 8'hFF, 8'd0);
		send_op(OP_NEW, 8'd0, 8'd0);
		send_op(OP_DELETE, 8'd0, 8'd0);
		send_op(OP_READ, 8'd0, 8'd0);
		send_op(OP_CLOSE, 8'd0, 8'd0);
		send_op(OP_READ, 8'd0, 8'd0);
		send_op(OP_CLEAR, 8'd0, 8'd0);
		send_op(OP_OPEN, 8'd0, 8'd0);
		wait_drained();
	endtask

	// Writes and reads run past the end of a body.
	task automatic test_body_end();
		send_op(OP_CLEAR, 8'd0, 8'd0);
		send_op(OP_NEW, 8'd0, 8'd0);
		repeat (BODY_BYTES + 1) send_op(OP_WRITE, 8'($urandom), 8'($urandom));
		send_op(OP_OPEN, 8'd0, 8'd0);
		repeat (BODY_BYTES + 1) send_op(OP_READ, 8'($urandom), 8'($urandom));
		send_op(OP_WRITE, 8'd0, 8'h5A);
		wait_drained();
	endtask

	// The receiver stalls for a long stretch while operations keep coming.
	task automatic test_backpressure();
		hold_request = 1'b1;
		send_idle_pct = 0;
		send_op(OP_NEW, 8'd0, 8'd0);
		repeat (14) send_op(OP_WRITE, 8'd0, 8'($urandom));
		send_op(OP_QUERY, 8'd0, 8'd0);
		wait_drained();
	endtask

	// Mostly well-formed sessions: creates and opens followed by character streams.
	task automatic test_random_traffic(input int count);
		int start;
		int pick;
		int burst;
		start = items_sent;
		while (items_sent - start < count) begin
			pick  = $urandom_range(99);
			burst = ($urandom_range(9) == 0) ? $urandom_range(100, BODY_BYTES + 8)
			                                 : $urandom_range(0, 12);
			if (pick < 18) begin
				send_op(OP_NEW, 8'($urandom), 8'($urandom));
				repeat (burst) send_op(OP_WRITE, 8'($urandom), 8'($urandom));
			end else if (pick < 34) begin
				send_op(OP_OPEN, 8'($urandom_range(SLOT_COUNT)), 8'($urandom));
				repeat (burst) send_op(OP_READ, 8'($urandom), 8'($urandom));
			end else if (pick < 44) begin
				send_op(OP_DELETE, 8'($urandom_range(SLOT_COUNT)), 8'($urandom));
			end else if (pick < 54) begin
				send_op(OP_QUERY, 8'($urandom_range(SLOT_COUNT)), 8'($urandom));
			end else if (pick < 58) begin
				send_op(OP_CLEAR, 8'($urandom), 8'($urandom));
			end else if (pick < 65) begin
				send_op(OP_CLOSE, 8'($urandom), 8'($urandom));
			end else if (pick < 80) begin
				send_op($urandom_range(1) ? OP_WRITE : OP_READ, 8'($urandom), 8'($urandom));
			end else begin
				// Noise: any operation with any index.
				send_op(OP_W'($urandom_range(7)), 8'($urandom), 8'($urandom));
			end
		end
		wait_drained();
	endtask

	// Sequence of tests and the final verdict.
	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = OP_CLOSE;
		mismatch_count = 0;
		items_sent     = 0;
		send_idle_pct  = 0;
		recv_idle_pct  = 0;
		hold_request   = 1'b0;
		shadow_count   = 0;
		shadow_base    = '0;
		shadow_pos     = 0;
		shadow_open    = 1'b0;
		for (int k = 0; k < SLOT_COUNT; k++)
			shadow_slots[k] = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 33;
		recv_idle_pct = 82;
		test_directed();
		test_body_end();
		test_random_traffic(PHASE_ITEMS);

		send_idle_pct = 82;
		recv_idle_pct = 33;
		test_random_traffic(PHASE_ITEMS);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_random_traffic(PHASE_ITEMS);

		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#10000000;
		$display("Verification failed");
		$finish;
	end

endmodule
